>>> rtl/assert_macros.svh
// Assertion macros shared by the button decoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_PROP(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks that a condition holds at every rising clock edge outside reset.
`define ASSERT_COMB(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

`endif

>>> rtl/dcbd_pkg.sv
// Types, constants and decode functions for the debounced chord button decoder.
package dcbd_pkg;

	localparam int KEY_W  = 6;
	localparam int TIME_W = 48;
	localparam int DEB_W  = 20;
	localparam int CNT_W  = 3;
	localparam int CODE_W = 4;

	// Configuration register indexes.
	localparam logic REG_DEBOUNCE = 1'b0;
	localparam logic REG_COUNT    = 1'b1;

	localparam logic [DEB_W-1:0] DEBOUNCE_RESET = DEB_W'(20000);
	localparam logic [CNT_W-1:0] COUNT_RESET    = CNT_W'(6);

	// Chord masks.
	localparam logic [KEY_W-1:0] CHORD_AB = KEY_W'((1 << 4) | (1 << 5));
	localparam logic [KEY_W-1:0] CHORD_LR = KEY_W'((1 << 2) | (1 << 3));
	localparam logic [KEY_W-1:0] CHORD_UD = KEY_W'((1 << 0) | (1 << 1));

	// Pad codes.
	localparam logic [CODE_W-1:0] CODE_NONE = 4'd0;
	localparam logic [CODE_W-1:0] CODE_AB   = 4'd3;
	localparam logic [CODE_W-1:0] CODE_LR   = 4'd2;
	localparam logic [CODE_W-1:0] CODE_UD   = 4'd8;

	// Direct codes for up, down, left, right, A and B.
	localparam logic [CODE_W-1:0] SINGLE_CODE [KEY_W] = '{
		4'd6, 4'd7, 4'd5, 4'd4, 4'd0, 4'd1
	};

	// Result of one sample.
	typedef struct packed {
		logic              valid;
		logic [CODE_W-1:0] code;
	} res_t;

	// Mask of the buttons present; a count above six acts as six.
	function automatic logic [KEY_W-1:0] keep_mask(input logic [CNT_W-1:0] cnt);
		logic [KEY_W-1:0] k;
		k = '0;
		for (int i = 0; i < KEY_W; i++) begin
			k[i] = (CNT_W'(i) < cnt);
		end
		return k;
	endfunction

	// Decodes the keys seen during one press into a pad event.
	function automatic res_t decode_seen(input logic [KEY_W-1:0] m,
			input logic [CNT_W-1:0] cnt);
		res_t r;
		r.valid = 1'b0;
		r.code  = CODE_NONE;
		if (m == CHORD_AB) begin
			r.valid = 1'b1;
			r.code  = CODE_AB;
		end else if (m == CHORD_LR) begin
			r.valid = 1'b1;
			r.code  = CODE_LR;
		end else if (m == CHORD_UD) begin
			r.valid = 1'b1;
			r.code  = CODE_UD;
		end else begin
			for (int i = 0; i < KEY_W; i++) begin
				if ((m == (KEY_W'(1) << i)) && (CNT_W'(i) < cnt)) begin
					r.valid = 1'b1;
					r.code  = SINGLE_CODE[i];
				end
			end
		end
		return r;
	endfunction

endpackage

>>> rtl/dcbd_regs.sv
// Configuration registers: debounce time and button count.
module dcbd_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write,
	input  logic                        cfg_index,
	input  logic [dcbd_pkg::DEB_W-1:0]  cfg_data,
	output logic [dcbd_pkg::DEB_W-1:0]  debounce_us,
	output logic [dcbd_pkg::CNT_W-1:0]  button_count,
	output logic [dcbd_pkg::KEY_W-1:0]  keep
);
	import dcbd_pkg::*;

	logic [DEB_W-1:0] debounce_q;
	logic [CNT_W-1:0] count_q;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
			count_q    <= COUNT_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_DEBOUNCE: debounce_q <= cfg_data;
				REG_COUNT:    count_q    <= cfg_data[CNT_W-1:0];
				default:      ;
			endcase
		end
	end

	assign debounce_us  = debounce_q;
	assign button_count = count_q;
	assign keep         = keep_mask(count_q);

endmodule

>>> rtl/dcbd_debounce.sv
// Debounce state, seen-key tracking and release decoding for one sample.
`include "assert_macros.svh"

module dcbd_debounce (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        commit,
	input  logic [dcbd_pkg::KEY_W-1:0]  raw,
	input  logic [dcbd_pkg::TIME_W-1:0] now,
	input  logic [dcbd_pkg::DEB_W-1:0]  debounce_us,
	input  logic [dcbd_pkg::CNT_W-1:0]  button_count,
	output dcbd_pkg::res_t              res
);
	import dcbd_pkg::*;

	logic [KEY_W-1:0]  last_raw_q;
	logic [TIME_W-1:0] changed_time_q;
	logic [KEY_W-1:0]  stable_q;
	logic [KEY_W-1:0]  seen_q;

	logic              changed;
	logic [TIME_W-1:0] elapsed;
	logic              settle;
	logic              release_now;

	// Elapsed time wraps with the timestamp; a new stable mask needs a
	// steady sample that has held long enough.
	assign changed     = (raw != last_raw_q);
	assign elapsed     = now - changed_time_q;
	assign settle      = !changed && (elapsed >= TIME_W'(debounce_us)) && (raw != stable_q);
	assign release_now = settle && (raw == '0);

	// An event is reported only on a release of a recognised key set.
	always_comb begin
		if (release_now) begin
			res = decode_seen(seen_q, button_count);
		end else begin
			res.valid = 1'b0;
			res.code  = CODE_NONE;
		end
	end

	// State update once the sample moves on to the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_raw_q     <= '0;
			changed_time_q <= '0;
			stable_q       <= '0;
			seen_q         <= '0;
		end else if (commit) begin
			if (changed) begin
				last_raw_q     <= raw;
				changed_time_q <= now;
			end else if (settle) begin
				stable_q <= raw;
				if (release_now) begin
					seen_q <= '0;
				end else begin
					seen_q <= seen_q | raw;
				end
			end
		end
	end

	// The keys held now are always among the keys seen in this press.
	`ASSERT_COMB(a_stable_in_seen, (stable_q & ~seen_q) == '0, "stable keys missing from seen mask")
	// With nothing held, no keys remain recorded.
	`ASSERT_COMB(a_idle_seen_clear, (stable_q != '0) || (seen_q == '0), "seen mask left after release")
	// A reported event leaves the pad released with the seen mask cleared.
	`ASSERT_PROP(a_event_release, (commit && res.valid) |=> (stable_q == '0 && seen_q == '0), "event without release")

endmodule

>>> rtl/debounced_chord_button_decoder.sv
// Top level of the debounced chord button decoder.
// Takes one button sample per clock while in_stall is low and returns exactly one
// result per sample, in order. A request is captured in the input register, passes
// through the debounce and decode logic and is written to the result register, from
// which it is offered; the state update of the debounce logic sets the sustained
// rate of one sample per cycle while the output is not stalled. Configuration writes
// take effect on the next cycle and must only be made while no sample is in flight.
`include "assert_macros.svh"

module debounced_chord_button_decoder (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write,
	input  logic                         cfg_index,
	input  logic [dcbd_pkg::DEB_W-1:0]   cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [dcbd_pkg::KEY_W-1:0]   raw_mask,
	input  logic [dcbd_pkg::TIME_W-1:0]  now_us,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         event_valid,
	output logic [dcbd_pkg::CODE_W-1:0]  event_code
);
	import dcbd_pkg::*;

	logic [DEB_W-1:0]  debounce_us;
	logic [CNT_W-1:0]  button_count;
	logic [KEY_W-1:0]  keep;

	logic              s1_valid_q;
	logic [KEY_W-1:0]  raw_s1;
	logic [TIME_W-1:0] now_s1;

	logic              out_valid_q;
	res_t              res_q;
	res_t              res;
	logic              advance;
	logic              commit;

	dcbd_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.debounce_us  (debounce_us),
		.button_count (button_count),
		.keep         (keep)
	);

	// The result register frees up when empty or when its request is taken.
	assign advance  = !out_valid_q || !out_stall;
	assign commit   = s1_valid_q && advance;
	assign in_stall = s1_valid_q && !advance;

	// Input register; absent buttons are masked off on entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!in_stall) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			raw_s1 <= raw_mask & keep;
			now_s1 <= now_us;
		end
	end

	dcbd_debounce u_debounce (
		.clk          (clk),
		.arst_n       (arst_n),
		.commit       (commit),
		.raw          (raw_s1),
		.now          (now_s1),
		.debounce_us  (debounce_us),
		.button_count (button_count),
		.res          (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			res_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign event_valid = res_q.valid;
	assign event_code  = res_q.code;

	// The input only holds off when a request is waiting in the input register.
	`ASSERT_COMB(a_stall_needs_item, !in_stall || s1_valid_q, "input stalled with empty stage")
	// A result without an event carries a zero code.
	`ASSERT_COMB(a_code_zero, !out_valid_q || res_q.valid || (res_q.code == CODE_NONE), "code set without event")
	// A waiting sample moves on as soon as the result register frees up.
	`ASSERT_PROP(a_moves_on, (s1_valid_q && advance && !(in_valid && !in_stall)) |=> !s1_valid_q, "stage did not drain")

endmodule
